// ----- design/thtmr_pkg.sv -----
// Shared types and constants for the trickle HELLO timer.
`timescale 1ns / 1ps

package thtmr_pkg;

  localparam int unsigned MaxNeighbours = 32;

  localparam int unsigned LenW   = 31;
  localparam int unsigned MinW   = 21;
  localparam int unsigned DblW   = 4;
  localparam int unsigned RedW   = 8;
  localparam int unsigned HeardW = 6;
  localparam int unsigned NewnW  = 8;
  localparam int unsigned RndW   = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 21;

  // event codes
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_HELLO = 3'd1;
  localparam logic [2:0] OP_NEWN  = 3'd2;
  localparam logic [2:0] OP_START = 3'd3;
  localparam logic [2:0] OP_STOP  = 3'd4;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_MIN_INTERVAL = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_DOUBLE   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_REDUNDANCY   = 2'd2;

  localparam logic [MinW-1:0] MIN_RESET = 21'd3840;
  localparam logic [DblW-1:0] DBL_RESET = 4'd8;
  localparam logic [RedW-1:0] RED_RESET = 8'd2;
  localparam logic [LenW-1:0] CAP_RESET = 31'd983040;  // 3840 << 8

  typedef struct packed {
    logic [2:0]        op;
    logic [4:0]        neighbour_index;
    logic [5:0]        neighbour_total;
    logic [RndW-1:0]   random_value;
  } in_beat_t;

  typedef struct packed {
    logic              send_hello;
    logic              running;
    logic [LenW-1:0]   interval_now;
    logic [HeardW-1:0] heard_count;
  } out_beat_t;

  typedef struct packed {
    logic [MinW-1:0] min_ticks;
    logic [LenW-1:0] cap;
    logic [RedW-1:0] redund;
  } cfg_t;

endpackage

// ----- design/thtmr_cfg.sv -----
// Configuration registers and the precomputed interval cap.
`timescale 1ns / 1ps

module thtmr_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [thtmr_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [thtmr_pkg::CfgDataW-1:0]    cfg_data_i,
  output thtmr_pkg::cfg_t                   cfg_o
);

  logic [thtmr_pkg::MinW-1:0] min_q;
  logic [thtmr_pkg::DblW-1:0] dbl_q;
  logic [thtmr_pkg::RedW-1:0] red_q;
  logic [thtmr_pkg::LenW-1:0] cap_q, cap_d;
  logic [thtmr_pkg::MinW-1:0] min_new;
  logic [thtmr_pkg::DblW-1:0] dbl_new;

  // Imin << doublings, saturated to the interval width
  function automatic logic [thtmr_pkg::LenW-1:0] cap_of(
    input logic [thtmr_pkg::MinW-1:0] mn,
    input logic [thtmr_pkg::DblW-1:0] dbl
  );
    logic [thtmr_pkg::MinW+15-1:0] wide;
    wide = {15'd0, mn} << dbl;
    if (wide[thtmr_pkg::MinW+15-1:thtmr_pkg::LenW] != '0) begin
      cap_of = '1;
    end else begin
      cap_of = wide[thtmr_pkg::LenW-1:0];
    end
  endfunction

  assign cfg_ready_o = 1'b1;

  always_comb begin
    min_new = min_q;
    dbl_new = dbl_q;
    case (cfg_index_i)
      thtmr_pkg::CFG_MIN_INTERVAL: min_new = cfg_data_i[thtmr_pkg::MinW-1:0];
      thtmr_pkg::CFG_MAX_DOUBLE:   dbl_new = cfg_data_i[thtmr_pkg::DblW-1:0];
      default: ;
    endcase
    cap_d = cap_of(min_new, dbl_new);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= thtmr_pkg::MIN_RESET;
      dbl_q <= thtmr_pkg::DBL_RESET;
      red_q <= thtmr_pkg::RED_RESET;
      cap_q <= thtmr_pkg::CAP_RESET;
    end else if (cfg_valid_i) begin
      min_q <= min_new;
      dbl_q <= dbl_new;
      cap_q <= cap_d;
      if (cfg_index_i == thtmr_pkg::CFG_REDUNDANCY) begin
        red_q <= cfg_data_i[thtmr_pkg::RedW-1:0];
      end
    end
  end

  assign cfg_o.min_ticks = min_q;
  assign cfg_o.cap       = cap_q;
  assign cfg_o.redund    = red_q;

endmodule

// ----- design/thtmr_core.sv -----
// Trickle timer state and the per-event update.
`timescale 1ns / 1ps

module thtmr_core #(
  parameter int unsigned MAX_NEIGHBOURS = thtmr_pkg::MaxNeighbours
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  thtmr_pkg::in_beat_t  beat_i,
  input  thtmr_pkg::cfg_t      cfg_i,
  output thtmr_pkg::out_beat_t res_o
);

  localparam int unsigned LenW = thtmr_pkg::LenW;
  localparam int unsigned RndW = thtmr_pkg::RndW;

  logic                         active_q, active_d;
  logic [LenW-1:0]              len_q, len_d;
  logic [LenW-1:0]              elapsed_q, elapsed_d;
  logic [LenW-1:0]              fire_pt_q, fire_pt_d;
  logic                         past_q, past_d;
  logic [thtmr_pkg::HeardW-1:0] heard_q, heard_d;
  logic [thtmr_pkg::NewnW-1:0]  newn_q, newn_d;
  logic [MAX_NEIGHBOURS-1:0]    flags_q, flags_d;

  logic                         send;
  logic                         begin_iv;
  logic [LenW-1:0]              base;
  logic [LenW:0]                dbl;
  logic [LenW-1:0]              new_len;
  logic [LenW-1:0]              half;
  logic [LenW-1:0]              span;
  logic [LenW+RndW-1:0]         prod;
  logic [LenW-1:0]              el_inc;
  logic [LenW-1:0]              min_half;
  logic [thtmr_pkg::NewnW-1:0]  newn_inc;
  logic [3:0]                   need;
  logic                         slot_hit;
  logic                         slot_set;

  assign min_half = {{(LenW-thtmr_pkg::MinW+1){1'b0}}, cfg_i.min_ticks[thtmr_pkg::MinW-1:1]};
  assign el_inc   = elapsed_q + 1'b1;
  assign newn_inc = (newn_q == '1) ? newn_q : newn_q + 1'b1;
  assign need     = (beat_i.neighbour_total[5:2] == 4'd0) ? 4'd1
                                                          : beat_i.neighbour_total[5:2];

  // new interval: double the base, cap it, place the fire point in [I/2, I)
  assign base    = (beat_i.op == thtmr_pkg::OP_TICK) ? len_q : min_half;
  assign dbl     = {base, 1'b0};
  assign new_len = (dbl > {1'b0, cfg_i.cap}) ? cfg_i.cap : dbl[LenW-1:0];
  assign half    = new_len >> 1;
  assign span    = new_len - half;
  assign prod    = beat_i.random_value * span;

  always_comb begin
    slot_hit = 1'b0;
    for (int i = 0; i < MAX_NEIGHBOURS; i++) begin
      if (int'(beat_i.neighbour_index) == i) begin
        slot_hit = slot_hit | flags_q[i];
      end
    end
  end
  assign slot_set = (int'(beat_i.neighbour_index) < MAX_NEIGHBOURS) && !slot_hit;

  always_comb begin
    active_d  = active_q;
    len_d     = len_q;
    elapsed_d = elapsed_q;
    fire_pt_d = fire_pt_q;
    past_d    = past_q;
    heard_d   = heard_q;
    newn_d    = newn_q;
    flags_d   = flags_q;
    send      = 1'b0;
    begin_iv  = 1'b0;

    case (beat_i.op)
      thtmr_pkg::OP_TICK: begin
        if (active_q) begin
          elapsed_d = el_inc;
          if (!past_q && el_inc >= fire_pt_q) begin
            past_d = 1'b1;
            if ({2'b00, heard_q} < cfg_i.redund) begin
              send    = 1'b1;
              flags_d = '0;
            end
          end
          begin_iv = (el_inc >= len_q);
        end
      end
      thtmr_pkg::OP_HELLO: begin
        if (slot_set) begin
          for (int i = 0; i < MAX_NEIGHBOURS; i++) begin
            if (int'(beat_i.neighbour_index) == i) begin
              flags_d[i] = 1'b1;
            end
          end
          if (heard_q != '1) begin
            heard_d = heard_q + 1'b1;
          end
        end
      end
      thtmr_pkg::OP_NEWN: begin
        newn_d   = newn_inc;
        begin_iv = active_q && (newn_inc >= {4'd0, need}) &&
                   (len_q != {{(LenW-thtmr_pkg::MinW){1'b0}}, cfg_i.min_ticks});
      end
      thtmr_pkg::OP_START: begin
        if (!active_q) begin
          active_d = 1'b1;
          send     = 1'b1;
          begin_iv = 1'b1;
        end
      end
      thtmr_pkg::OP_STOP: begin
        active_d = 1'b0;
      end
      default: ;
    endcase

    if (begin_iv) begin
      len_d     = new_len;
      heard_d   = '0;
      newn_d    = '0;
      elapsed_d = '0;
      past_d    = 1'b0;
      fire_pt_d = half + prod[LenW+RndW-1:RndW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      len_q     <= '0;
      elapsed_q <= '0;
      fire_pt_q <= '0;
      past_q    <= 1'b0;
      heard_q   <= '0;
      newn_q    <= '0;
      flags_q   <= '0;
    end else if (fire_i) begin
      active_q  <= active_d;
      len_q     <= len_d;
      elapsed_q <= elapsed_d;
      fire_pt_q <= fire_pt_d;
      past_q    <= past_d;
      heard_q   <= heard_d;
      newn_q    <= newn_d;
      flags_q   <= flags_d;
    end
  end

  assign res_o.send_hello   = send;
  assign res_o.running      = active_d;
  assign res_o.interval_now = len_d;
  assign res_o.heard_count  = heard_d;

endmodule

// ----- design/trickle_hello_timer_top.sv -----
// Top level of the trickle HELLO timer: input register, update, result register.
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// in        sink       in_valid_i/in_stall_o   in_data_i   (in_beat_t)
// out       source     out_valid_o/out_stall_i out_data_o  (out_beat_t)
// cfg       sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One event per cycle while the output is not stalled; each beat passes through
// the input register and then the result register.
// Reset clears timer state and the heard flags; config returns to defaults.
// A stall on the output holds the result register and then the input register;
// the input stalls only when both are full.

module trickle_hello_timer_top #(
  parameter int unsigned MAX_NEIGHBOURS = thtmr_pkg::MaxNeighbours
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  thtmr_pkg::in_beat_t               in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output thtmr_pkg::out_beat_t              out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [thtmr_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [thtmr_pkg::CfgDataW-1:0]    cfg_data_i
);

  thtmr_pkg::in_beat_t  in_q;
  logic                 in_valid_q;
  thtmr_pkg::out_beat_t out_q;
  logic                 out_valid_q;
  thtmr_pkg::out_beat_t res;
  thtmr_pkg::cfg_t      cfg;
  logic                 out_free;
  logic                 fire;
  logic                 take;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign take       = in_valid_i && !in_stall_o;

  thtmr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  thtmr_core #(
    .MAX_NEIGHBOURS (MAX_NEIGHBOURS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .beat_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q <= in_data_i;
    end
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- test/thtmr_hello_checker.sv -----
// Watches the timer's channels, predicts each result beat and compares it.
`timescale 1ns / 1ps

module thtmr_hello_checker
  import thtmr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  in_beat_t            in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  out_beat_t           out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         pending_o,
  output int unsigned         errors_o
);

  localparam longint unsigned LenMax   = 64'h7FFF_FFFF;
  localparam int unsigned     HeardMax = 63;
  localparam int unsigned     NewnMax  = 255;
  localparam int unsigned     NewnDiv  = 4;

  // configuration copy
  logic [MinW-1:0] min_ticks = MIN_RESET;
  logic [DblW-1:0] doublings = DBL_RESET;
  logic [RedW-1:0] redund    = RED_RESET;

  // timer copy
  logic                      active    = 1'b0;
  logic [LenW-1:0]           ilen      = '0;
  logic [31:0]               elapsed   = '0;
  logic [LenW-1:0]           fire      = '0;
  logic                      past_fire = 1'b0;
  logic [HeardW-1:0]         heard     = '0;
  logic [NewnW-1:0]          newn      = '0;
  logic [MaxNeighbours-1:0]  flags     = '0;

  out_beat_t   due_results[$];
  int unsigned mismatches = 0;

  assign errors_o = mismatches;

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // interval begin: double I up to the cap, clear counters, place the fire point
  function automatic void open_interval(input logic [RndW-1:0] rnd);
    longint unsigned cap, dbl, half;
    cap = 64'(min_ticks) << doublings;
    if (cap > LenMax) cap = LenMax;
    dbl = 64'(ilen) * 2;
    ilen = (dbl > cap) ? LenW'(cap) : LenW'(dbl);
    heard = '0;
    newn = '0;
    elapsed = '0;
    past_fire = 1'b0;
    half = 64'(ilen) / 2;
    fire = LenW'(half + ((64'(rnd) * (64'(ilen) - half)) >> 16));
  endfunction

  function automatic out_beat_t advance_timer(input in_beat_t ev);
    logic        send;
    int unsigned need;
    out_beat_t   res;
    send = 1'b0;
    case (ev.op)
      OP_TICK: begin
        if (active) begin
          elapsed++;
          if (!past_fire && elapsed >= 32'(fire)) begin
            past_fire = 1'b1;
            if (8'(heard) < redund) begin
              send = 1'b1;
              flags = '0;
            end
          end
          // fire and interval end can land on the same tick
          if (elapsed >= 32'(ilen)) open_interval(ev.random_value);
        end
      end
      OP_HELLO: begin
        if (ev.neighbour_index < MaxNeighbours && !flags[ev.neighbour_index]) begin
          flags[ev.neighbour_index] = 1'b1;
          if (heard < HeardMax) heard++;
        end
      end
      OP_NEWN: begin
        need = ev.neighbour_total / NewnDiv;
        if (need < 1) need = 1;
        if (newn < NewnMax) newn++;
        if (active && newn >= need && ilen != LenW'(min_ticks)) begin
          ilen = LenW'(min_ticks / 2);
          open_interval(ev.random_value);
        end
      end
      OP_START: begin
        if (!active) begin
          active = 1'b1;
          send = 1'b1;
          ilen = LenW'(min_ticks / 2);
          open_interval(ev.random_value);
        end
      end
      OP_STOP: active = 1'b0;
      default: ;
    endcase
    res.send_hello   = send;
    res.running      = active;
    res.interval_now = ilen;
    res.heard_count  = heard;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      min_ticks = MIN_RESET;
      doublings = DBL_RESET;
      redund = RED_RESET;
      active = 1'b0;
      ilen = '0;
      elapsed = '0;
      fire = '0;
      past_fire = 1'b0;
      heard = '0;
      newn = '0;
      flags = '0;
      due_results.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MIN_INTERVAL: min_ticks = cfg_data_i[MinW-1:0];
          CFG_MAX_DOUBLE:   doublings = cfg_data_i[DblW-1:0];
          CFG_REDUNDANCY:   redund = cfg_data_i[RedW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          report_mismatch("result beat with nothing due", out_data_i, 0);
        end else begin
          want = due_results.pop_front();
          if (out_data_i.send_hello !== want.send_hello)
            report_mismatch("send_hello", out_data_i.send_hello, want.send_hello);
          if (out_data_i.running !== want.running)
            report_mismatch("running", out_data_i.running, want.running);
          if (out_data_i.interval_now !== want.interval_now)
            report_mismatch("interval_now", out_data_i.interval_now, want.interval_now);
          if (out_data_i.heard_count !== want.heard_count)
            report_mismatch("heard_count", out_data_i.heard_count, want.heard_count);
        end
      end
      if (in_valid_i && !in_stall_i) due_results.push_back(advance_timer(in_data_i));
      pending_o <= due_results.size();
    end
  end

endmodule

// ----- test/trickle_hello_timer_top_test.sv -----
// Stimulus and verdict for the trickle HELLO timer top level.
`timescale 1ns / 1ps

module trickle_hello_timer_top_test;
  import thtmr_pkg::*;

  localparam int TwistNone  = 0;
  localparam int TwistHold  = 1;
  localparam int TwistDrain = 2;
  localparam int HoldCycles = 100;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_beat_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_beat_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  int unsigned         pending;
  int unsigned         errors;

  int unsigned burst_left = 0;
  bit          steady = 1'b0;
  bit          hold_req = 1'b0;

  trickle_hello_timer_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  thtmr_hello_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // result side: stall pattern changes every segment; a hold request wins
  initial begin
    int seg;
    int mode;
    int hold_left;
    hold_left = 0;
    forever begin
      seg = $urandom_range(8, 60);
      mode = $urandom_range(0, 3);
      repeat (seg) begin
        @(posedge clk);
        if (hold_req) begin
          hold_req = 1'b0;
          hold_left = HoldCycles;
        end
        if (hold_left > 0) begin
          hold_left--;
          out_stall <= 1'b1;
        end else begin
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(3) == 0);
            2:       out_stall <= ($urandom_range(3) != 0);
            default: out_stall <= ~out_stall;
          endcase
        end
      end
    end
  end

  function automatic in_beat_t mk(input logic [2:0] op, input logic [4:0] idx,
                                  input logic [5:0] tot, input logic [RndW-1:0] rnd);
    in_beat_t ev;
    ev.op = op;
    ev.neighbour_index = idx;
    ev.neighbour_total = tot;
    ev.random_value = rnd;
    return ev;
  endfunction

  function automatic in_beat_t random_event();
    in_beat_t ev;
    int pick;
    ev.neighbour_index = 5'($urandom_range(31));
    ev.neighbour_total = 6'($urandom_range(63));
    ev.random_value = RndW'($urandom);
    pick = $urandom_range(99);
    if (pick < 55) ev.op = OP_TICK;
    else if (pick < 70) ev.op = OP_HELLO;
    else if (pick < 80) ev.op = OP_NEWN;
    else if (pick < 88) ev.op = OP_START;
    else if (pick < 93) ev.op = OP_STOP;
    else ev.op = OP_STOP + 3'($urandom_range(1, 3));  // undefined codes
    return ev;
  endfunction

  // sender works in bursts; a gap may open before each new burst
  task automatic offer(input in_beat_t ev);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= ev;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_settings(input logic [MinW-1:0] imin, input logic [DblW-1:0] dbl,
                                input logic [RedW-1:0] red);
    cfg_write(CFG_MIN_INTERVAL, CfgDataW'(imin));
    cfg_write(CFG_MAX_DOUBLE, CfgDataW'(dbl));
    cfg_write(CFG_REDUNDANCY, CfgDataW'(red));
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [MinW-1:0] imin, input logic [DblW-1:0] dbl,
                           input logic [RedW-1:0] red, input int n, input int twist);
    apply_settings(imin, dbl, red);
    offer(mk(OP_START, '0, '0, RndW'($urandom)));
    for (int i = 0; i < n; i++) begin
      if (twist == TwistHold && i == 10) begin
        steady = 1'b1;
        hold_req = 1'b1;
      end
      if (twist == TwistHold && i == 60) steady = 1'b0;
      if (twist == TwistDrain && i == n / 2) begin
        in_valid <= 1'b0;
        drain();
      end
      offer(random_event());
    end
    in_valid <= 1'b0;
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default settings straight out of reset
    offer(mk(OP_START, 5'd0, 6'd0, 16'h8000));
    offer(mk(OP_TICK, 5'd0, 6'd0, 16'h0000));
    offer(mk(OP_NEWN, 5'd0, 6'd63, 16'h1234));
    offer(mk(OP_STOP, 5'd0, 6'd0, 16'h0000));
    in_valid <= 1'b0;
    drain();

    // directed: small interval so fire points and interval ends show up
    apply_settings(21'd2, 4'd1, 8'd1);
    offer(mk(OP_START, 5'd0, 6'd0, 16'h0000));
    offer(mk(OP_TICK, 5'd31, 6'd63, 16'hFFFF));
    offer(mk(OP_TICK, 5'd0, 6'd0, 16'h0000));
    offer(mk(OP_HELLO, 5'd0, 6'd0, 16'h0000));
    offer(mk(OP_HELLO, 5'd31, 6'd0, 16'h0000));
    offer(mk(OP_HELLO, 5'd0, 6'd0, 16'h0000));
    offer(mk(OP_TICK, 5'd0, 6'd0, 16'h0000));
    offer(mk(OP_TICK, 5'd0, 6'd0, 16'hFFFF));
    offer(mk(OP_STOP + 3'd1, 5'd31, 6'd63, 16'hFFFF));
    offer(mk(OP_STOP + 3'd2, 5'd0, 6'd0, 16'h0000));
    offer(mk(OP_STOP + 3'd3, 5'd0, 6'd0, 16'h0000));
    offer(mk(OP_NEWN, 5'd0, 6'd0, 16'h0000));
    offer(mk(OP_NEWN, 5'd0, 6'd63, 16'hFFFF));
    offer(mk(OP_START, 5'd0, 6'd0, 16'hFFFF));
    offer(mk(OP_STOP, 5'd0, 6'd0, 16'h0000));
    offer(mk(OP_STOP, 5'd0, 6'd0, 16'h0000));
    offer(mk(OP_TICK, 5'd0, 6'd0, 16'h0000));
    offer(mk(OP_NEWN, 5'd0, 6'd4, 16'h0000));
    offer(mk(OP_HELLO, 5'd5, 6'd0, 16'h0000));
    offer(mk(OP_START, 5'd0, 6'd0, 16'hFFFF));
    offer(mk(OP_TICK, 5'd0, 6'd0, 16'h0000));
    offer(mk(OP_TICK, 5'd0, 6'd0, 16'h0000));
    offer(mk(OP_TICK, 5'd0, 6'd0, 16'h0000));
    in_valid <= 1'b0;
    drain();

    run_phase(21'd2, 4'd0, 8'd1, 90, TwistNone);
    run_phase(21'd4, 4'd3, 8'd2, 110, TwistHold);
    run_phase(21'd0, 4'd5, 8'd1, 60, TwistNone);
    run_phase(21'd1, 4'd10, 8'd255, 80, TwistDrain);
    run_phase(21'd8, 4'd2, 8'd0, 110, TwistNone);
    run_phase(21'h1F_FFFF, 4'd15, 8'd3, 40, TwistNone);
    run_phase(21'd3, 4'd4, 8'd2, 120, TwistNone);
    run_phase(21'd2, 4'd10, 8'd3, 100, TwistNone);

    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/thtmr_pkg.sv
design/thtmr_cfg.sv
design/thtmr_core.sv
design/trickle_hello_timer_top.sv
test/thtmr_hello_checker.sv
test/trickle_hello_timer_top_test.sv
